// File: hw/rtl/sipb_pkg.sv
`timescale 1ns / 1ps

package sipb_pkg;

    localparam logic [15:0] CRC_POLY = 16'h8005;

    // config register indexes
    localparam logic [1:0] CFG_FIRST_ID  = 2'd0;
    localparam logic [1:0] CFG_SECOND_ID = 2'd1;
    localparam logic [1:0] CFG_THIRD_ID  = 2'd2;

    localparam logic ACTION_TORQUE = 1'b1;

    typedef logic [5:0] t_pc;

    localparam t_pc STEP_TORQUE = 6'd27;
    localparam t_pc STEP_CRC    = 6'd37;
    localparam t_pc STEP_LAST   = 6'd38;

    typedef enum logic [2:0] {
        SRC_CONST,
        SRC_HELD_ID,
        SRC_TORQUE,
        SRC_CFG_ID,
        SRC_GOAL,
        SRC_CRC_LO,
        SRC_CRC_HI
    } t_src;

    typedef enum logic [1:0] {
        J_NEXT,
        J_IF_TORQUE,
        J_ALWAYS,
        J_END
    } t_jmp;

    typedef struct packed {
        t_src       src;
        logic [7:0] konst;
        logic [1:0] sel;    // servo slot for cfg id / goal
        logic [1:0] bsel;   // goal byte, low first
        t_jmp       jmp;
        t_pc        target;
    } t_uop;

    typedef struct packed {
        logic clr;
        logic feed;
    } t_crc_ctl;

    function automatic logic [15:0] crc16_feed(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Microcode program. Header 0..3, sync write 4..26, torque 27..36, CRC 37..38.
    function automatic t_uop uop_rom(t_pc pc);
        t_uop u;
        u = '{src: SRC_CONST, konst: 8'h00, sel: 2'd0, bsel: 2'd0,
              jmp: J_NEXT, target: 6'd0};
        unique case (pc)
            6'd0:  u.konst = 8'hFF;
            6'd1:  u.konst = 8'hFF;
            6'd2:  u.konst = 8'hFD;
            6'd3:  begin
                u.konst  = 8'h00;
                u.jmp    = J_IF_TORQUE;
                u.target = STEP_TORQUE;
            end
            // sync write body
            6'd4:  u.konst = 8'hFE;
            6'd5:  u.konst = 8'h16;
            6'd6:  u.konst = 8'h00;
            6'd7:  u.konst = 8'h83;
            6'd8:  u.konst = 8'h74;
            6'd9:  u.konst = 8'h00;
            6'd10: u.konst = 8'h04;
            6'd11: u.konst = 8'h00;
            6'd12: begin u.src = SRC_CFG_ID; u.sel = 2'd0; end
            6'd13: begin u.src = SRC_GOAL; u.sel = 2'd0; u.bsel = 2'd0; end
            6'd14: begin u.src = SRC_GOAL; u.sel = 2'd0; u.bsel = 2'd1; end
            6'd15: begin u.src = SRC_GOAL; u.sel = 2'd0; u.bsel = 2'd2; end
            6'd16: begin u.src = SRC_GOAL; u.sel = 2'd0; u.bsel = 2'd3; end
            6'd17: begin u.src = SRC_CFG_ID; u.sel = 2'd1; end
            6'd18: begin u.src = SRC_GOAL; u.sel = 2'd1; u.bsel = 2'd0; end
            6'd19: begin u.src = SRC_GOAL; u.sel = 2'd1; u.bsel = 2'd1; end
            6'd20: begin u.src = SRC_GOAL; u.sel = 2'd1; u.bsel = 2'd2; end
            6'd21: begin u.src = SRC_GOAL; u.sel = 2'd1; u.bsel = 2'd3; end
            6'd22: begin u.src = SRC_CFG_ID; u.sel = 2'd2; end
            6'd23: begin u.src = SRC_GOAL; u.sel = 2'd2; u.bsel = 2'd0; end
            6'd24: begin u.src = SRC_GOAL; u.sel = 2'd2; u.bsel = 2'd1; end
            6'd25: begin u.src = SRC_GOAL; u.sel = 2'd2; u.bsel = 2'd2; end
            6'd26: begin
                u.src    = SRC_GOAL;
                u.sel    = 2'd2;
                u.bsel   = 2'd3;
                u.jmp    = J_ALWAYS;
                u.target = STEP_CRC;
            end
            // torque body
            6'd27: u.src = SRC_HELD_ID;
            6'd28: u.konst = 8'h09;
            6'd29: u.konst = 8'h00;
            6'd30: u.konst = 8'h03;
            6'd31: u.konst = 8'h40;
            6'd32: u.konst = 8'h00;
            6'd33: u.src = SRC_TORQUE;
            6'd34: u.konst = 8'h00;
            6'd35: u.konst = 8'h00;
            6'd36: u.konst = 8'h00;
            // trailer
            6'd37: u.src = SRC_CRC_LO;
            6'd38: begin u.src = SRC_CRC_HI; u.jmp = J_END; end
            default: begin u.src = SRC_CRC_HI; u.jmp = J_END; end
        endcase
        return u;
    endfunction

endpackage

// File: hw/rtl/sipb_crc16.sv
`timescale 1ns / 1ps

module sipb_crc16 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sipb_pkg::t_crc_ctl  i_ctl,
    input  logic [7:0]          i_byte,
    output logic [15:0]         o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        priority if (i_ctl.clr) begin
            n_crc = 16'h0000;
        end else if (i_ctl.feed) begin
            n_crc = sipb_pkg::crc16_feed(r_crc, i_byte);
        end else begin
            n_crc = r_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= 16'h0000;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

// File: hw/rtl/servo_instruction_packet_builder_top.sv
`timescale 1ns / 1ps

// Builds one servo-bus instruction packet per command and sends it one byte per
// output beat, CRC-16 (0x8005) low byte then high byte at the end, last_byte set
// on the final beat. A torque command gives 16 beats, a sync write 29. A small
// microcode ROM steps once per byte, whenever the output register is empty or
// being read; the next command is taken in the cycle its predecessor's final byte
// enters the output register, so back-to-back packets stream without gaps.
// Servo ids for the sync write come from three config registers, which the user
// must write only while no packet is in flight; the block does not enforce it.

module servo_instruction_packet_builder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // command channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [7:0]  i_servo_id,
    input  logic        i_torque_on,
    input  logic [31:0] i_goal_first,
    input  logic [31:0] i_goal_second,
    input  logic [31:0] i_goal_third,
    // byte channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_packet_byte,
    output logic        o_last_byte
);

    logic [7:0]        r_cfg_id [3];
    logic              r_kind;
    logic [7:0]        r_held_id;
    logic              r_torque;
    logic [31:0]       r_goal [3];

    sipb_pkg::t_pc     r_pc;
    sipb_pkg::t_pc     n_pc;
    logic              r_busy;
    logic              n_busy;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;

    sipb_pkg::t_uop    uop;
    sipb_pkg::t_crc_ctl crc_ctl;
    logic [15:0]       crc;
    logic [7:0]        step_byte;
    logic [7:0]        cfg_sel;
    logic [31:0]       goal_sel;
    logic              fire;
    logic              finish;
    logic              accept;

    assign uop    = sipb_pkg::uop_rom(r_pc);
    assign fire   = r_busy && (!r_out_valid || i_out_ready);
    assign finish = fire && (uop.jmp == sipb_pkg::J_END);
    assign o_in_ready = !r_busy || finish;
    assign accept = i_in_valid && o_in_ready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_id[0] <= 8'd3;
            r_cfg_id[1] <= 8'd2;
            r_cfg_id[2] <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sipb_pkg::CFG_FIRST_ID:  r_cfg_id[0] <= i_cfg_data;
                sipb_pkg::CFG_SECOND_ID: r_cfg_id[1] <= i_cfg_data;
                sipb_pkg::CFG_THIRD_ID:  r_cfg_id[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // command hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= 1'b0;
            r_held_id <= 8'h00;
            r_torque  <= 1'b0;
        end else if (accept) begin
            r_kind    <= i_action;
            r_held_id <= i_servo_id;
            r_torque  <= i_torque_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_goal[0] <= i_goal_first;
            r_goal[1] <= i_goal_second;
            r_goal[2] <= i_goal_third;
        end
    end

    // datapath byte select
    always_comb begin
        unique case (uop.sel)
            2'd0:    cfg_sel = r_cfg_id[0];
            2'd1:    cfg_sel = r_cfg_id[1];
            default: cfg_sel = r_cfg_id[2];
        endcase
    end

    always_comb begin
        unique case (uop.sel)
            2'd0:    goal_sel = r_goal[0];
            2'd1:    goal_sel = r_goal[1];
            default: goal_sel = r_goal[2];
        endcase
    end

    always_comb begin
        unique case (uop.src)
            sipb_pkg::SRC_CONST:   step_byte = uop.konst;
            sipb_pkg::SRC_HELD_ID: step_byte = r_held_id;
            sipb_pkg::SRC_TORQUE:  step_byte = {7'd0, r_torque};
            sipb_pkg::SRC_CFG_ID:  step_byte = cfg_sel;
            sipb_pkg::SRC_GOAL:    step_byte = goal_sel[{uop.bsel, 3'b000} +: 8];
            sipb_pkg::SRC_CRC_LO:  step_byte = crc[7:0];
            sipb_pkg::SRC_CRC_HI:  step_byte = crc[15:8];
            default:               step_byte = 8'h00;
        endcase
    end

    always_comb begin
        crc_ctl.clr  = accept;
        crc_ctl.feed = fire && (uop.src != sipb_pkg::SRC_CRC_LO)
                            && (uop.src != sipb_pkg::SRC_CRC_HI);
    end

    sipb_crc16 u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .i_byte  (step_byte),
        .o_crc   (crc)
    );

    // sequencer
    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (fire) begin
            unique case (uop.jmp)
                sipb_pkg::J_NEXT:      n_pc = r_pc + 6'd1;
                sipb_pkg::J_IF_TORQUE: n_pc = (r_kind == sipb_pkg::ACTION_TORQUE)
                                              ? uop.target : r_pc + 6'd1;
                sipb_pkg::J_ALWAYS:    n_pc = uop.target;
                sipb_pkg::J_END:       n_busy = 1'b0;
            endcase
        end
        if (accept) begin
            n_pc   = 6'd0;
            n_busy = 1'b1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= 6'd0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_byte <= step_byte;
            r_out_last <= (uop.jmp == sipb_pkg::J_END);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_packet_byte = r_out_byte;
    assign o_last_byte   = r_out_last;

    a_accept_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy && (r_pc == 6'd0))
        else $error("sequencer did not restart on new command");

    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_pc <= sipb_pkg::STEP_LAST)
        else $error("step counter left the program");

    a_end_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> o_out_valid && o_last_byte)
        else $error("final step did not flag last beat");

    a_torque_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !accept && (r_pc == 6'd3) && (r_kind == sipb_pkg::ACTION_TORQUE)
        |=> r_pc == sipb_pkg::STEP_TORQUE)
        else $error("torque branch not taken after header");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam logic       ACTION_SYNC      = ~sipb_pkg::ACTION_TORQUE;
    localparam logic [1:0] CFG_SPARE        = 2'd3;
    localparam logic [7:0] INSTR_WRITE      = 8'h03;
    localparam logic [7:0] INSTR_SYNC_WRITE = 8'h83;
    localparam logic [7:0] ADDR_TORQUE      = 8'h40;
    localparam logic [7:0] ADDR_GOAL        = 8'h74;
    localparam logic [7:0] LEN_TORQUE       = 8'h09;
    localparam logic [7:0] LEN_SYNC         = 8'h16;
    localparam logic [7:0] BROADCAST_ID     = 8'hFE;
    localparam logic [7:0] GOAL_BYTES       = 8'h04;
    localparam int         NO_CHECK         = -1;
    localparam int         N_DIRECTED       = 16;
    localparam int         N_PHASES         = 7;
    localparam int         ITEMS_PER_PHASE  = 65;
    localparam int         SETTLE_CYCLES    = 8;
    localparam int         CYCLE_LIMIT      = 600000;

    typedef struct packed {
        logic        action;
        logic [7:0]  servo_id;
        logic        torque_on;
        logic [31:0] goal_first;
        logic [31:0] goal_second;
        logic [31:0] goal_third;
        int          check_pos;   // byte position with a hand-typed value
        logic [7:0]  check_val;
    } t_command;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_wire_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_action;
    logic [7:0]  i_servo_id;
    logic        i_torque_on;
    logic [31:0] i_goal_first;
    logic [31:0] i_goal_second;
    logic [31:0] i_goal_third;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_packet_byte;
    logic        o_last_byte;

    int          row_check_pos;
    logic [7:0]  row_check_val;

    logic [7:0]  first_id  = 8'd3;
    logic [7:0]  second_id = 8'd2;
    logic [7:0]  third_id  = 8'd1;

    t_wire_byte  bytes_due [$];
    int          error_count = 0;
    bit          gaps_on;
    int          burst_left = 0;

    t_command directed_rows [N_DIRECTED] = '{
        '{ACTION_SYNC,   8'h00, 1'b0, 32'h0,        32'h0,        32'h0,        12, 8'h03},
        '{ACTION_SYNC,   8'h00, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 17, 8'h02},
        '{ACTION_SYNC,   8'h00, 1'b0, 32'h04030201, 32'h08070605, 32'h0C0B0A09, 13, 8'h01},
        '{ACTION_SYNC,   8'h00, 1'b0, 32'h0,        32'h0,        32'h80000000, 26, 8'h80},
        '{sipb_pkg::ACTION_TORQUE, 8'h00, 1'b1, 32'h0, 32'h0, 32'h0,            10, 8'h01},
        '{sipb_pkg::ACTION_TORQUE, 8'hFD, 1'b0, 32'h0, 32'h0, 32'h0,            4,  8'hFD},
        '{sipb_pkg::ACTION_TORQUE, 8'hFE, 1'b1, 32'h0, 32'h0, 32'h0,            4,  8'hFE},
        '{sipb_pkg::ACTION_TORQUE, 8'hFF, 1'b1, 32'h0, 32'h0, 32'h0,            4,  8'hFF},
        '{sipb_pkg::ACTION_TORQUE, 8'h01, 1'b0, 32'hFFFFFFFF, 32'h00001234, 32'hDEADBEEF,
          13, 8'h00},
        '{ACTION_SYNC,   8'hFF, 1'b1, 32'h1,        32'h2,        32'h3,        4,  BROADCAST_ID},
        '{sipb_pkg::ACTION_TORQUE, 8'h55, 1'b1, 32'h0, 32'h0, 32'h0,            5,  LEN_TORQUE},
        '{sipb_pkg::ACTION_TORQUE, 8'hAA, 1'b0, 32'h0, 32'h0, 32'h0,            8,  ADDR_TORQUE},
        '{ACTION_SYNC,   8'h00, 1'b0, 32'h55555555, 32'hAAAAAAAA, 32'h12345678, 18, 8'hAA},
        '{ACTION_SYNC,   8'h00, 1'b0, 32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF, 7,
          INSTR_SYNC_WRITE},
        '{sipb_pkg::ACTION_TORQUE, 8'h7F, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
          11, 8'h00},
        '{ACTION_SYNC,   8'h00, 1'b0, 32'h00000001, 32'h80000000, 32'h7FFFFFFF, NO_CHECK, 8'h00}
    };

    servo_instruction_packet_builder_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_servo_id    (i_servo_id),
        .i_torque_on   (i_torque_on),
        .i_goal_first  (i_goal_first),
        .i_goal_second (i_goal_second),
        .i_goal_third  (i_goal_third),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_packet_byte (o_packet_byte),
        .o_last_byte   (o_last_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // CRC-16/0x8005, data shifted in msb first against the register top bit
    function automatic logic [15:0] crc_next(logic [15:0] crc, logic [7:0] data);
        logic fb;
        for (int k = 7; k >= 0; k--) begin
            fb  = crc[15] ^ data[k];
            crc = {crc[14:0], 1'b0};
            if (fb) begin
                crc = crc ^ sipb_pkg::CRC_POLY;
            end
        end
        return crc;
    endfunction

    task automatic predict_packet(input t_command c);
        logic [7:0]  body [0:26];
        logic [31:0] goals [3];
        logic [7:0]  ids [3];
        logic [15:0] crc;
        t_wire_byte  wb;
        int          len;
        body[0] = 8'hFF;
        body[1] = 8'hFF;
        body[2] = 8'hFD;
        body[3] = 8'h00;
        if (c.action == sipb_pkg::ACTION_TORQUE) begin
            body[4]  = c.servo_id;
            body[5]  = LEN_TORQUE;
            body[6]  = 8'h00;
            body[7]  = INSTR_WRITE;
            body[8]  = ADDR_TORQUE;
            body[9]  = 8'h00;
            body[10] = {7'd0, c.torque_on};
            body[11] = 8'h00;
            body[12] = 8'h00;
            body[13] = 8'h00;
            len = 14;
        end else begin
            goals[0] = c.goal_first;
            goals[1] = c.goal_second;
            goals[2] = c.goal_third;
            ids[0]   = first_id;
            ids[1]   = second_id;
            ids[2]   = third_id;
            body[4]  = BROADCAST_ID;
            body[5]  = LEN_SYNC;
            body[6]  = 8'h00;
            body[7]  = INSTR_SYNC_WRITE;
            body[8]  = ADDR_GOAL;
            body[9]  = 8'h00;
            body[10] = GOAL_BYTES;
            body[11] = 8'h00;
            for (int s = 0; s < 3; s++) begin
                body[12 + 5 * s] = ids[s];
                for (int b = 0; b < 4; b++) begin
                    body[13 + 5 * s + b] = goals[s][8 * b +: 8];
                end
            end
            len = 27;
        end
        crc = 16'h0000;
        for (int i = 0; i < len; i++) begin
            crc = crc_next(crc, body[i]);
        end
        for (int i = 0; i < len + 2; i++) begin
            if (i < len) begin
                wb.value = body[i];
            end else if (i == len) begin
                wb.value = crc[7:0];
            end else begin
                wb.value = crc[15:8];
            end
            wb.last = (i == len + 1);
            if (i == c.check_pos) begin
                wb.value = c.check_val;
            end
            bytes_due.push_back(wb);
        end
    endtask

    function automatic logic [31:0] random_goal();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            2: return $urandom_range(0, 4095);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_command random_command();
        t_command c;
        c.action      = 1'($urandom_range(0, 1));
        c.servo_id    = 8'($urandom_range(0, 255));
        c.torque_on   = 1'($urandom_range(0, 1));
        c.goal_first  = random_goal();
        c.goal_second = random_goal();
        c.goal_third  = random_goal();
        c.check_pos   = NO_CHECK;
        c.check_val   = 8'h00;
        return c;
    endfunction

    // Called right after a rising edge; returns right after the accepting edge
    // or after the idle gap that follows it.
    task automatic send_command(input t_command c);
        int idle;
        i_action      <= c.action;
        i_servo_id    <= c.servo_id;
        i_torque_on   <= c.torque_on;
        i_goal_first  <= c.goal_first;
        i_goal_second <= c.goal_second;
        i_goal_third  <= c.goal_third;
        row_check_pos <= c.check_pos;
        row_check_val <= c.check_val;
        i_in_valid    <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 8);
                idle       = $urandom_range(1, 30);
                i_in_valid <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (bytes_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_ids(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sipb_pkg::CFG_FIRST_ID;
        i_cfg_data <= a;
        @(posedge i_clk);
        i_cfg_idx  <= sipb_pkg::CFG_SECOND_ID;
        i_cfg_data <= b;
        @(posedge i_clk);
        i_cfg_idx  <= sipb_pkg::CFG_THIRD_ID;
        i_cfg_data <= c;
        @(posedge i_clk);
        // spare index must leave all ids alone
        i_cfg_idx  <= CFG_SPARE;
        i_cfg_data <= 8'($urandom_range(0, 255));
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        first_id   = a;
        second_id  = b;
        third_id   = c;
    endtask

    // receiver stall pattern with a randomly reshuffled mode
    always @(posedge i_clk) begin : out_stall_pattern
        int ready_cycle;
        int stall_mode;
        if (ready_cycle % 128 == 0) begin
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: i_out_ready <= (ready_cycle % 4 == 0);
            default: i_out_ready <= (ready_cycle % 16 >= 5);
        endcase
        ready_cycle++;
    end

    always @(posedge i_clk) begin : packet_checker
        t_wire_byte want;
        t_command   taken;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (bytes_due.size() == 0) begin
                    $display("%0t: unexpected beat, packet_byte %h last_byte %b",
                             $time, o_packet_byte, o_last_byte);
                    error_count++;
                end else begin
                    want = bytes_due.pop_front();
                    if (o_packet_byte !== want.value) begin
                        $display("%0t: packet_byte expected %h actual %h",
                                 $time, want.value, o_packet_byte);
                        error_count++;
                    end
                    if (o_last_byte !== want.last) begin
                        $display("%0t: last_byte expected %b actual %b",
                                 $time, want.last, o_last_byte);
                        error_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                taken.action      = i_action;
                taken.servo_id    = i_servo_id;
                taken.torque_on   = i_torque_on;
                taken.goal_first  = i_goal_first;
                taken.goal_second = i_goal_second;
                taken.goal_third  = i_goal_third;
                taken.check_pos   = row_check_pos;
                taken.check_val   = row_check_val;
                predict_packet(taken);
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] id_a;
        logic [7:0] id_b;
        logic [7:0] id_c;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= sipb_pkg::CFG_FIRST_ID;
        i_cfg_data    <= 8'h00;
        i_in_valid    <= 1'b0;
        i_action      <= ACTION_SYNC;
        i_servo_id    <= 8'h00;
        i_torque_on   <= 1'b0;
        i_goal_first  <= 32'h0;
        i_goal_second <= 32'h0;
        i_goal_third  <= 32'h0;
        row_check_pos <= NO_CHECK;
        row_check_val <= 8'h00;
        gaps_on = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows run on the reset ids
        for (int r = 0; r < N_DIRECTED; r++) begin
            send_command(directed_rows[r]);
        end
        hold_until_drained();

        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: begin id_a = 8'd0;   id_b = 8'd0;   id_c = 8'd0;   end
                1: begin id_a = 8'd252; id_b = 8'd252; id_c = 8'd252; end
                2: begin id_a = 8'd253; id_b = 8'd254; id_c = 8'd255; end
                3: begin id_a = 8'd255; id_b = 8'd0;   id_c = 8'd252; end
                default: begin
                    id_a = 8'($urandom_range(0, 255));
                    id_b = 8'($urandom_range(0, 255));
                    id_c = 8'($urandom_range(0, 255));
                end
            endcase
            load_ids(id_a, id_b, id_c);
            gaps_on    = (phase % 3 != 1);
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 3 && n == 30) begin
                    hold_until_drained();
                end
                send_command(random_command());
            end
            hold_until_drained();
        end

        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
